@@ src/lpf_pkg.sv @@
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared types, codes and helpers for the length-prefixed packet FIFO.
// ----------------------------------------------------------------------------
package lpf_pkg;

    // Ring size in 16-bit words
    localparam int FIFO_DEPTH_WORDS = 2048;
    localparam int PTR_W  = $clog2(FIFO_DEPTH_WORDS);
    localparam int USE_W  = PTR_W + 1;
    localparam int CNT_W  = 12;
    localparam int SUM_W  = ((USE_W > CNT_W + 1) ? USE_W : CNT_W + 1) + 1;
    localparam int WORD_W = 16;
    localparam int LEN_W  = 12;

    // Request kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_POP   = 2'd2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DROP    = 3'd1,
        ST_DISCARD = 3'd2,
        ST_READ    = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    // Writer mode
    typedef enum logic [2:0] {
        WM_IDLE  = 3'b001,
        WM_STORE = 3'b010,
        WM_DROP  = 3'b100
    } t_wmode;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;    // request accepted this cycle
        logic finish;  // RAM read data valid this cycle
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_read;  // current request is a pop that fetches a word
    } t_dp_flags;

    // Advance a ring pointer with wrap
    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(FIFO_DEPTH_WORDS - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // Data words needed for a byte length: ceil(len/2)
    function automatic logic [CNT_W-1:0] f_words(input logic [LEN_W-1:0] len);
        logic [LEN_W:0] s;
        s = {1'b0, len} + (LEN_W + 1)'(1);
        return s[LEN_W:1];
    endfunction

endpackage

@@ src/lpf_if.sv @@
// ----------------------------------------------------------------------------
// lpf_if
// Valid/ready channel interfaces for the packet FIFO requests and results.
// ----------------------------------------------------------------------------
interface lpf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] length_bytes;
    logic [15:0] data_in;

    modport source (output valid, output kind, output length_bytes, output data_in,
                    input ready);
    modport sink   (input valid, input kind, input length_bytes, input data_in,
                    output ready);
endinterface

interface lpf_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] data_out;
    logic        is_length;
    logic        last_word;

    modport source (output valid, output status, output data_out, output is_length,
                    output last_word, input ready);
    modport sink   (input valid, input status, input data_out, input is_length,
                    input last_word, output ready);
endinterface

@@ src/lpf_ram.sv @@
// ----------------------------------------------------------------------------
// lpf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/lpf_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpf_ctrl
// Handshake controller: accepts requests, waits out RAM reads, owns result valid.
// ----------------------------------------------------------------------------
module lpf_ctrl
    import lpf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    input  t_dp_flags i_flags,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_dp_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   exec;

    // Take a request when idle and the result register is free or draining
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign exec       = i_in_valid && o_in_ready;

    assign o_cmd.exec   = exec;
    assign o_cmd.finish = (r_state == S_READ);
    assign o_out_valid  = r_out_valid;

    // Advance state and result valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (exec) begin
                    if (i_flags.need_read) begin
                        n_state = S_READ;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_READ: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_read_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("result pending while a RAM read is in flight");

    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_IDLE) && r_out_valid)
        else $error("read did not complete into the result register");

    a_pop_enters_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && i_flags.need_read) |=> (r_state == S_READ))
        else $error("pop with data did not start a RAM read");
`endif

endmodule

@@ src/lpf_datapath.sv @@
// ----------------------------------------------------------------------------
// lpf_datapath
// Ring pointers, admission check, writer and reader counters, word RAM and
// the result register.
// ----------------------------------------------------------------------------
module lpf_datapath
    import lpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [1:0]        i_kind,
    input  logic [LEN_W-1:0]  i_length_bytes,
    input  logic [WORD_W-1:0] i_data_in,
    output t_dp_flags         o_flags,
    output logic [2:0]        o_res_status,
    output logic [WORD_W-1:0] o_data_out,
    output logic              o_is_length,
    output logic              o_last_word
);

    // Control state
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_wwl, n_wwl;
    logic [CNT_W-1:0] r_rwl, n_rwl;
    t_wmode           r_wmode, n_wmode;

    // Result register and pop context
    t_status           r_status, n_status;
    logic [WORD_W-1:0] r_dout, n_dout;
    logic              r_is_len, n_is_len;
    logic              r_last, n_last;
    logic              r_pop_hdr, n_pop_hdr;

    // RAM port signals
    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [WORD_W-1:0] ram_rdata;

    logic [CNT_W-1:0] words;
    logic [CNT_W-1:0] hdr_words;
    logic [USE_W-1:0] used;
    logic [SUM_W-1:0] need;
    logic             admit;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] wp_next;
    logic             fifo_empty;

    lpf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (FIFO_DEPTH_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    // Committed words not yet read
    always_comb begin
        if (r_head >= r_rp) begin
            used = {1'b0, r_head} - {1'b0, r_rp};
        end else begin
            used = {1'b0, r_head} + USE_W'(FIFO_DEPTH_WORDS) - {1'b0, r_rp};
        end
    end

    // Admission: used + 1 + words must stay below the ring size
    assign words     = f_words(i_length_bytes);
    assign need      = SUM_W'(used) + SUM_W'(words) + SUM_W'(1);
    assign admit     = (need < SUM_W'(FIFO_DEPTH_WORDS));
    assign head_next = f_next(r_head);
    assign wp_next   = f_next(r_wp);
    assign hdr_words = f_words(ram_rdata[LEN_W-1:0]);

    assign fifo_empty        = (r_rwl == '0) && (r_rp == r_head);
    assign o_flags.need_read = (i_kind == KIND_POP) && !fifo_empty;

    // Request execution and read completion
    always_comb begin
        n_head    = r_head;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_wwl     = r_wwl;
        n_rwl     = r_rwl;
        n_wmode   = r_wmode;
        n_status  = r_status;
        n_dout    = r_dout;
        n_is_len  = r_is_len;
        n_last    = r_last;
        n_pop_hdr = r_pop_hdr;
        ram_we    = 1'b0;
        ram_waddr = r_wp;
        ram_wdata = i_data_in;
        ram_re    = 1'b0;
        if (i_cmd.exec) begin
            n_status = ST_DISCARD;
            n_dout   = '0;
            n_is_len = 1'b0;
            n_last   = 1'b0;
            case (i_kind)
                KIND_START: begin
                    // Restart at the committed head, abandoning any partial packet
                    n_wwl = words;
                    if (admit) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_head;
                        ram_wdata = {{(WORD_W - LEN_W){1'b0}}, i_length_bytes};
                        n_wp      = head_next;
                        n_status  = ST_OK;
                        if (words == '0) begin
                            n_head  = head_next;
                            n_wmode = WM_IDLE;
                        end else begin
                            n_wmode = WM_STORE;
                        end
                    end else begin
                        n_wp     = r_head;
                        n_status = ST_DROP;
                        if (words == '0) begin
                            n_wmode = WM_IDLE;
                        end else begin
                            n_wmode = WM_DROP;
                        end
                    end
                end
                KIND_DATA: begin
                    if ((r_wmode == WM_STORE) && (r_wwl != '0)) begin
                        // Store and commit on the final word
                        ram_we   = 1'b1;
                        n_wp     = wp_next;
                        n_wwl    = r_wwl - CNT_W'(1);
                        n_status = ST_OK;
                        if (r_wwl == CNT_W'(1)) begin
                            n_head  = wp_next;
                            n_wmode = WM_IDLE;
                        end
                    end else if ((r_wmode == WM_DROP) && (r_wwl != '0)) begin
                        // Count off a refused packet's word
                        n_wwl = r_wwl - CNT_W'(1);
                        if (r_wwl == CNT_W'(1)) begin
                            n_wmode = WM_IDLE;
                        end
                    end else begin
                        n_wmode = WM_IDLE;
                        n_wwl   = '0;
                    end
                end
                KIND_POP: begin
                    if (fifo_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        ram_re    = 1'b1;
                        n_rp      = f_next(r_rp);
                        n_pop_hdr = (r_rwl == '0);
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.finish) begin
            // Fill the result from the fetched word
            n_status = ST_READ;
            n_dout   = ram_rdata;
            if (r_pop_hdr) begin
                n_rwl    = hdr_words;
                n_is_len = 1'b1;
                n_last   = (hdr_words == '0);
            end else begin
                n_rwl    = r_rwl - CNT_W'(1);
                n_is_len = 1'b0;
                n_last   = (r_rwl == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_wwl   <= '0;
            r_rwl   <= '0;
            r_wmode <= WM_IDLE;
        end else begin
            r_head  <= n_head;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_wwl   <= n_wwl;
            r_rwl   <= n_rwl;
            r_wmode <= n_wmode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_dout    <= n_dout;
        r_is_len  <= n_is_len;
        r_last    <= n_last;
        r_pop_hdr <= n_pop_hdr;
    end

    assign o_res_status = r_status;
    assign o_data_out   = r_dout;
    assign o_is_length  = r_is_len;
    assign o_last_word  = r_last;

`ifndef SYNTHESIS
    a_idle_no_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wmode == WM_IDLE) |-> (r_wwl == '0))
        else $error("writer idle with words still expected");

    a_busy_has_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_wmode == WM_STORE) || (r_wmode == WM_DROP)) |-> (r_wwl != '0))
        else $error("writer storing or dropping with no words left");
`endif

endmodule

@@ src/length_prefixed_packet_fifo_unit.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_packet_fifo_unit
// Receive packet FIFO of 16-bit words with a length header per packet.
// ----------------------------------------------------------------------------
// Each request returns one result. A packet start, a data word, a discarded
// word and a pop of an empty FIFO need no RAM read; a pop that returns a word
// waits for the registered read of the single word RAM. The result
// register frees the input as soon as the result is taken, so a new request
// may enter in the same cycle. Only complete packets are visible to pops; a
// new start abandons an unfinished packet. The word RAM needs no clearing
// after reset, so requests are accepted right away.
module length_prefixed_packet_fifo_unit
    import lpf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpf_in_if.sink    i_in,
    lpf_out_if.source o_out
);

    t_dp_cmd   cmd;
    t_dp_flags flags;

    lpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_flags     (flags),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    lpf_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_kind         (i_in.kind),
        .i_length_bytes (i_in.length_bytes),
        .i_data_in      (i_in.data_in),
        .o_flags        (flags),
        .o_res_status   (o_out.status),
        .o_data_out     (o_out.data_out),
        .o_is_length    (o_out.is_length),
        .o_last_word    (o_out.last_word)
    );

endmodule
